[rtl/core/lmt_pkg.sv]
// shared constants, types and helpers for the largest multiple of three digit block
package lmt_pkg;

    // capacity and derived widths
    localparam int MaxDigits = 64;
    localparam int AddrW     = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
    localparam int CntW      = $clog2(MaxDigits + 1);
    localparam int DigitW    = 4;
    localparam int DigitBase = 10;
    localparam logic [DigitW-1:0] DigitMax  = DigitW'(DigitBase - 1);
    localparam logic [DigitW-1:0] DigitEnd  = DigitW'(DigitBase);
    localparam logic [DigitW-1:0] DigitZero = '0;

    // request to the histogram bank: one increment or decrement per cycle
    typedef struct packed {
        logic              inc;
        logic              dec;
        logic [DigitW-1:0] idx;
    } hist_op_t;

    // remainder of a digit by three
    function automatic logic [1:0] mod3(input logic [DigitW-1:0] v);
        logic [1:0] r;
        case (v)
            4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
            4'd12, 4'd15:            r = 2'd0;
            4'd13:                   r = 2'd1;
            4'd14:                   r = 2'd2;
            default:                 r = 2'd0;
        endcase
        return r;
    endfunction

    // running sum remainder by three
    function automatic logic [1:0] add_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 3'd3)
        begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

endpackage

[rtl/core/lmt_digit_store.sv]
// digit memory, one write and one registered read port
module lmt_digit_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [lmt_pkg::AddrW-1:0]   wr_addr,
    input  logic [lmt_pkg::DigitW-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [lmt_pkg::AddrW-1:0]   rd_addr,
    output logic [lmt_pkg::DigitW-1:0]  rd_data
);

    logic [lmt_pkg::DigitW-1:0] mem [lmt_pkg::MaxDigits];
    logic [lmt_pkg::DigitW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/lmt_hist.sv]
// per-value digit counters behind one shared increment/decrement unit
module lmt_hist (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lmt_pkg::hist_op_t          op,
    output logic [lmt_pkg::CntW-1:0]   cnt
);

    logic [lmt_pkg::CntW-1:0] hist_reg [lmt_pkg::DigitBase];
    logic [lmt_pkg::CntW-1:0] upd;
    logic                     in_range;

    // selected counter, values past nine read as empty
    assign in_range = (op.idx < lmt_pkg::DigitEnd);
    assign cnt      = in_range ? hist_reg[op.idx] : '0;

    // shared add/subtract unit
    assign upd = op.inc ? (cnt + lmt_pkg::CntW'(1)) : (cnt - lmt_pkg::CntW'(1));

    // counter bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lmt_pkg::DigitBase; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if ((op.inc || op.dec) && in_range)
        begin
            hist_reg[op.idx] <= upd;
        end
    end

endmodule

[rtl/core/largest_multiple_of_three_digits_top.sv]
// top level: digit loading, counting sweep, removal scan and result emission
//
// Usage: digits arrive on the input channel (in_valid/in_ready, digit_in,
// final_digit), one request per cycle while the block is loading. Digits
// above nine count as nine. Up to 64 digits are kept; later ones are dropped
// and overflowed is raised on every result of that number. The request with
// final_digit set ends the number (even when it is itself dropped).
// After the final request in_ready stays low while the block works:
//   counting sweep over the N kept digits (one memory read a cycle,
//   registered read data), removal scan over the ten digit values,
//   emission: one result a cycle while the receiver takes them, with a
//   step past each digit value that has no digits left.
// All steps share one counter add/subtract unit on the ten-entry histogram.
// Results leave on the output channel (out_valid/out_ready) largest digit
// first, run_end on the last. When nothing remains a single result with
// result_empty and run_end set is sent. A stalled receiver simply holds the
// output register; emission pauses until it is taken. Reset (rst_n, async,
// active low) drops any number in progress and returns to loading.
module largest_multiple_of_three_digits_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lmt_pkg::DigitW-1:0]  digit_in,
    input  logic                        final_digit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lmt_pkg::DigitW-1:0]  digit_out,
    output logic                        run_end,
    output logic                        result_empty,
    output logic                        overflowed
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SWEEP,
        S_DROP,
        S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [lmt_pkg::CntW-1:0]    count_reg, count_next;
    logic [lmt_pkg::CntW-1:0]    idx_reg, idx_next;
    logic [lmt_pkg::CntW-1:0]    left_reg, left_next;
    logic [1:0]                  rem_reg, rem_next;
    logic                        ovf_reg, ovf_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [lmt_pkg::DigitW-1:0]  val_reg, val_next;
    logic [1:0]                  need_reg, need_next;
    logic                        phase_b_reg, phase_b_next;
    logic                        out_valid_reg, out_valid_next;
    logic [lmt_pkg::DigitW-1:0]  digit_out_reg, digit_out_next;
    logic                        run_end_reg, run_end_next;
    logic                        empty_reg, empty_next;
    logic                        ovf_out_reg, ovf_out_next;

    logic                        in_acc;
    logic [lmt_pkg::DigitW-1:0]  digit_sat;
    logic                        wr_en;
    logic                        rd_en;
    logic [lmt_pkg::DigitW-1:0]  rd_data;
    lmt_pkg::hist_op_t           hop;
    logic [lmt_pkg::CntW-1:0]    hcnt;
    logic [1:0]                  target;
    logic                        out_free;

    // memory and histogram
    lmt_digit_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[lmt_pkg::AddrW-1:0]),
        .wr_data (digit_sat),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[lmt_pkg::AddrW-1:0]),
        .rd_data (rd_data)
    );

    lmt_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (hop),
        .cnt   (hcnt)
    );

    // handshake and input conditioning
    assign in_ready  = (state_reg == S_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign digit_sat = (digit_in > lmt_pkg::DigitMax) ? lmt_pkg::DigitMax : digit_in;
    assign wr_en     = in_acc && (count_reg < lmt_pkg::CntW'(lmt_pkg::MaxDigits));
    assign rd_en     = (state_reg == S_SWEEP) && (idx_reg < count_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign target    = phase_b_reg ? (2'd3 - rem_reg) : rem_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        rd_pend_next   = 1'b0;
        val_next       = val_reg;
        need_next      = need_reg;
        phase_b_next   = phase_b_reg;
        out_valid_next = out_valid_reg && !out_ready;
        digit_out_next = digit_out_reg;
        run_end_next   = run_end_reg;
        empty_next     = empty_reg;
        ovf_out_next   = ovf_out_reg;
        hop.inc        = 1'b0;
        hop.dec        = 1'b0;
        hop.idx        = val_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + lmt_pkg::CntW'(1);
                        rem_next   = lmt_pkg::add_mod3(rem_reg, lmt_pkg::mod3(digit_sat));
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_digit)
                    begin
                        idx_next   = '0;
                        state_next = S_SWEEP;
                    end
                end
            end

            S_SWEEP:
            begin
                // one read issued and one counted per cycle
                hop.idx      = rd_data;
                hop.inc      = rd_pend_reg;
                rd_pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + lmt_pkg::CntW'(1);
                end
                else if (!rd_pend_reg)
                begin
                    left_next    = count_reg;
                    need_next    = 2'd1;
                    phase_b_next = 1'b0;
                    if (rem_reg == 2'd0)
                    begin
                        val_next   = lmt_pkg::DigitMax;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        val_next   = lmt_pkg::DigitZero;
                        state_next = S_DROP;
                    end
                end
            end

            S_DROP:
            begin
                // smallest digits with the wanted remainder go first
                if (need_reg == 2'd0)
                begin
                    val_next   = lmt_pkg::DigitMax;
                    state_next = S_EMIT;
                end
                else if (val_reg == lmt_pkg::DigitEnd)
                begin
                    if (!phase_b_reg)
                    begin
                        phase_b_next = 1'b1;
                        need_next    = 2'd2;
                        val_next     = lmt_pkg::DigitZero;
                    end
                    else
                    begin
                        val_next   = lmt_pkg::DigitMax;
                        state_next = S_EMIT;
                    end
                end
                else if ((lmt_pkg::mod3(val_reg) == target) && (hcnt != '0))
                begin
                    hop.dec   = 1'b1;
                    need_next = need_reg - 2'd1;
                    left_next = left_reg - lmt_pkg::CntW'(1);
                end
                else
                begin
                    val_next = val_reg + lmt_pkg::DigitW'(1);
                end
            end

            S_EMIT:
            begin
                if (left_reg == '0)
                begin
                    // nothing left: single empty result
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        digit_out_next = lmt_pkg::DigitZero;
                        run_end_next   = 1'b1;
                        empty_next     = 1'b1;
                        ovf_out_next   = ovf_reg;
                        count_next     = '0;
                        rem_next       = 2'd0;
                        ovf_next       = 1'b0;
                        state_next     = S_LOAD;
                    end
                end
                else if (hcnt == '0)
                begin
                    val_next = val_reg - lmt_pkg::DigitW'(1);
                end
                else if (out_free)
                begin
                    hop.dec        = 1'b1;
                    left_next      = left_reg - lmt_pkg::CntW'(1);
                    out_valid_next = 1'b1;
                    digit_out_next = val_reg;
                    run_end_next   = (left_reg == lmt_pkg::CntW'(1));
                    empty_next     = 1'b0;
                    ovf_out_next   = ovf_reg;
                    if (left_reg == lmt_pkg::CntW'(1))
                    begin
                        count_next = '0;
                        rem_next   = 2'd0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            left_reg      <= '0;
            rem_reg       <= 2'd0;
            ovf_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            val_reg       <= '0;
            need_reg      <= 2'd0;
            phase_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            digit_out_reg <= '0;
            run_end_reg   <= 1'b0;
            empty_reg     <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            left_reg      <= left_next;
            rem_reg       <= rem_next;
            ovf_reg       <= ovf_next;
            rd_pend_reg   <= rd_pend_next;
            val_reg       <= val_next;
            need_reg      <= need_next;
            phase_b_reg   <= phase_b_next;
            out_valid_reg <= out_valid_next;
            digit_out_reg <= digit_out_next;
            run_end_reg   <= run_end_next;
            empty_reg     <= empty_next;
            ovf_out_reg   <= ovf_out_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digit_out    = digit_out_reg;
    assign run_end      = run_end_reg;
    assign result_empty = empty_reg;
    assign overflowed   = ovf_out_reg;

    // checks on the sequencer
    a_final_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && final_digit |=> !in_ready)
        else $error("input still ready after final digit");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lmt_pkg::CntW'(lmt_pkg::MaxDigits))
        else $error("digit count beyond capacity");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_empty |-> digit_out <= lmt_pkg::DigitMax)
        else $error("result digit out of range");

    a_empty_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_empty |-> run_end)
        else $error("empty result without run end");

endmodule

[tb/sv/largest_multiple_of_three_digits_top_test.sv]
// testbench for the largest multiple of three digit block: directed table, then random numbers
`timescale 1ns / 100ps

module largest_multiple_of_three_digits_top_test;

    // one result digit as it leaves the block
    typedef struct packed {
        logic [lmt_pkg::DigitW-1:0] digit;
        logic                       run_end;
        logic                       result_empty;
        logic                       overflowed;
    } digit_res_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [lmt_pkg::DigitW-1:0] digit;
        logic                       fin;
        logic                       typed;
        digit_res_t                 want;
    } dir_row_t;

    localparam int         NumDirected  = 24;
    localparam int         RandomDigits = 156;
    localparam int         DrainCycles  = 60;
    localparam digit_res_t NoTyped      = '0;
    localparam digit_res_t LoneZero     = '{lmt_pkg::DigitZero, 1'b1, 1'b0, 1'b0};
    localparam digit_res_t LoneNine     = '{lmt_pkg::DigitMax, 1'b1, 1'b0, 1'b0};
    localparam digit_res_t NothingLeft  = '{lmt_pkg::DigitZero, 1'b1, 1'b1, 1'b0};

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [lmt_pkg::DigitW-1:0] digit_in     = '0;
    logic                       final_digit  = 1'b0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic [lmt_pkg::DigitW-1:0] digit_out;
    logic                       run_end;
    logic                       result_empty;
    logic                       overflowed;

    // predictor state for the number being loaded
    logic [lmt_pkg::DigitW-1:0] held_digits [lmt_pkg::MaxDigits];
    int                         held_count;
    int                         held_sum;
    logic                       held_ovf;
    int                         digit_hist [10];

    digit_res_t        new_results [$];
    digit_res_t        expected_digits [$];
    int                mismatches;
    int                ready_stall;
    bit                quiet;

    // not-final rows, digits above nine, removals of one and two digits,
    // empty results and leading zeros
    dir_row_t dir_rows [NumDirected] = '{
        '{4'd0,  1'b1, 1'b1, LoneZero},
        '{4'd15, 1'b1, 1'b1, LoneNine},
        '{4'd1,  1'b1, 1'b1, NothingLeft},
        '{4'd2,  1'b1, 1'b1, NothingLeft},
        '{4'd1,  1'b0, 1'b0, NoTyped},
        '{4'd1,  1'b0, 1'b0, NoTyped},
        '{4'd10, 1'b1, 1'b0, NoTyped},
        '{4'd8,  1'b0, 1'b0, NoTyped},
        '{4'd1,  1'b0, 1'b0, NoTyped},
        '{4'd1,  1'b1, 1'b0, NoTyped},
        '{4'd5,  1'b0, 1'b0, NoTyped},
        '{4'd2,  1'b0, 1'b0, NoTyped},
        '{4'd0,  1'b1, 1'b0, NoTyped},
        '{4'd0,  1'b0, 1'b0, NoTyped},
        '{4'd0,  1'b0, 1'b0, NoTyped},
        '{4'd3,  1'b1, 1'b0, NoTyped},
        '{4'd0,  1'b0, 1'b0, NoTyped},
        '{4'd0,  1'b1, 1'b0, NoTyped},
        '{4'd14, 1'b0, 1'b0, NoTyped},
        '{4'd13, 1'b0, 1'b0, NoTyped},
        '{4'd12, 1'b0, 1'b0, NoTyped},
        '{4'd11, 1'b1, 1'b0, NoTyped},
        '{4'd7,  1'b0, 1'b0, NoTyped},
        '{4'd4,  1'b1, 1'b0, NoTyped}
    };

    largest_multiple_of_three_digits_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .digit_in     (digit_in),
        .final_digit  (final_digit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_out    (digit_out),
        .run_end      (run_end),
        .result_empty (result_empty),
        .overflowed   (overflowed)
    );

    always #10 clk = ~clk;

    // remove up to want digits of remainder rem from the histogram, smallest first
    function int strip_smallest(input int rem, input int want);
        int removed;
        removed = 0;
        for (int v = 0; v < 10; v++)
        begin
            if (v % 3 == rem)
            begin
                while (digit_hist[v] > 0 && removed < want)
                begin
                    digit_hist[v]--;
                    removed++;
                end
            end
        end
        return removed;
    endfunction

    // take one accepted digit; on the final one queue the largest multiple of three
    function void take_digit(input logic [lmt_pkg::DigitW-1:0] raw, input logic fin);
        logic [lmt_pkg::DigitW-1:0] d;
        int                         rem;
        int                         remaining;
        d = (raw > lmt_pkg::DigitMax) ? lmt_pkg::DigitMax : raw;
        if (held_count < lmt_pkg::MaxDigits)
        begin
            held_digits[held_count] = d;
            held_count++;
            held_sum += d;
        end
        else
        begin
            held_ovf = 1'b1;
        end
        if (!fin)
        begin
            return;
        end
        for (int v = 0; v < 10; v++)
        begin
            digit_hist[v] = 0;
        end
        for (int i = 0; i < held_count; i++)
        begin
            digit_hist[held_digits[i]]++;
        end
        // one digit of the sum's remainder, else two of the other remainder
        rem = held_sum % 3;
        if (rem != 0)
        begin
            if (strip_smallest(rem, 1) == 0)
            begin
                void'(strip_smallest(3 - rem, 2));
            end
        end
        remaining = 0;
        for (int v = 0; v < 10; v++)
        begin
            remaining += digit_hist[v];
        end
        if (remaining == 0)
        begin
            new_results.push_back('{lmt_pkg::DigitZero, 1'b1, 1'b1, held_ovf});
        end
        else
        begin
            for (int v = 9; v >= 0; v--)
            begin
                for (int c = 0; c < digit_hist[v]; c++)
                begin
                    remaining--;
                    new_results.push_back('{v[lmt_pkg::DigitW-1:0], remaining == 0, 1'b0,
                                            held_ovf});
                end
            end
        end
        held_count = 0;
        held_sum   = 0;
        held_ovf   = 1'b0;
    endfunction

    // mostly short gaps, a few long ones
    function int pick_gap();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // mostly decimal digits, some codes above nine
    function logic [lmt_pkg::DigitW-1:0] pick_digit();
        if ($urandom_range(0, 4) == 0)
        begin
            return lmt_pkg::DigitW'($urandom_range(10, 15));
        end
        return lmt_pkg::DigitW'($urandom_range(0, 9));
    endfunction

    task report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // drive one request, wait for it to be taken, then queue what it causes
    task send_digit(input logic [lmt_pkg::DigitW-1:0] d, input logic fin, input logic typed,
                    input digit_res_t want);
        int gap;
        in_valid    <= 1'b1;
        digit_in    <= d;
        final_digit <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        take_digit(d, fin);
        if (typed)
        begin
            expected_digits.push_back(want);
        end
        else
        begin
            foreach (new_results[i])
            begin
                expected_digits.push_back(new_results[i]);
            end
        end
        new_results.delete();
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: check each taken result, then choose the next ready level
    always @(posedge clk)
    begin
        digit_res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result digit %0d end %0b empty %0b",
                                              digit_out, run_end, result_empty));
                end
                else
                begin
                    want = expected_digits.pop_front();
                    // digit_out carries no meaning on an empty result
                    if (run_end !== want.run_end || result_empty !== want.result_empty
                        || overflowed !== want.overflowed
                        || (!want.result_empty && digit_out !== want.digit))
                    begin
                        report_mismatch($sformatf(
                            "got digit %0d end %0b empty %0b ovf %0b, want %0d %0b %0b %0b",
                            digit_out, run_end, result_empty, overflowed,
                            want.digit, want.run_end, want.result_empty, want.overflowed));
                    end
                end
            end
            if (ready_stall > 0 && !quiet)
            begin
                out_ready <= 1'b0;
                ready_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                ready_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int sent;
        int numbers;
        int len;
        held_count  = 0;
        held_sum    = 0;
        held_ovf    = 1'b0;
        mismatches  = 0;
        ready_stall = 0;
        quiet       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumDirected; i++)
        begin
            send_digit(dir_rows[i].digit, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
        end

        // random numbers: mostly short, now and then near or past capacity
        sent    = 0;
        numbers = 0;
        while (sent < RandomDigits)
        begin
            if (numbers == 1 || $urandom_range(0, 14) == 0)
            begin
                len = $urandom_range(62, 70);
            end
            else
            begin
                len = $urandom_range(1, 8);
            end
            // the last number is cut to the digits still to send
            if (len > RandomDigits - sent)
            begin
                len = RandomDigits - sent;
            end
            quiet = ($urandom_range(0, 5) == 0);
            for (int j = 0; j < len; j++)
            begin
                send_digit(pick_digit(), j == len - 1, 1'b0, NoTyped);
            end
            sent += len;
            numbers++;
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (expected_digits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS largest_multiple_of_three_digits_top");
        end
        else
        begin
            $display("FAIL largest_multiple_of_three_digits_top");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #50000000;
        $display("FAIL largest_multiple_of_three_digits_top");
        $finish;
    end

endmodule
